### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the Q7 FFT engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define Q7_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also evaluated while reset is asserted.
`define Q7_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/q7fft_pkg.sv
// ----------------------------------------------------------------------------
// q7fft_pkg
// Shared types and codes of the Q7 radix-2 FFT engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package q7fft_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Complex Q7 value; matches the store word layout (real in high byte)
  typedef struct packed {
    logic signed [7:0] re;
    logic signed [7:0] im;
  } cplx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REV_RD,
    ST_REV_CHK,
    ST_REV_WA,
    ST_REV_WB,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WE,
    ST_BF_WO
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/q7fft_twiddle_rom.sv
// ----------------------------------------------------------------------------
// q7fft_twiddle_rom
// Q7 twiddle table indexed by k = 0..POINTS/2-1, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q7fft_twiddle_rom
  import q7fft_pkg::*;
#(
  parameter int POINTS      = 1024,
  parameter int LOG2_POINTS = 10
) (
  input  wire logic                   clk,
  input  wire logic [LOG2_POINTS-2:0] addr,
  output cplx_t                       twiddle
);

  localparam int          QUARTER = POINTS / 4;
  localparam logic [63:0] PI_Q40  = 64'h3243F6A8885;

  // Round Q31 value times 128 half away from zero, clamp to int8
  function automatic logic [7:0] quant_q7(input longint v);
    logic        neg;
    logic [63:0] m;
    logic [63:0] q;
    neg = (v < 0);
    m   = neg ? 64'(-v) : 64'(v);
    q   = (m + 64'(1 << 23)) >> 24;
    if (neg) begin
      quant_q7 = (q > 64'd128) ? 8'h80 : 8'(-q);
    end else begin
      quant_q7 = (q > 64'd127) ? 8'h7f : q[7:0];
    end
  endfunction

  // Table of (cos, -sin) of 2*pi*k/POINTS, Taylor series in Q31
  function automatic logic [POINTS/2-1:0][15:0] build_table();
    logic [POINTS/2-1:0][15:0] tbl;
    logic [63:0]               x;
    logic [63:0]               t;
    longint                    cc;
    longint                    ss;
    longint                    c;
    longint                    s;
    int                        quad;
    int                        r;
    for (int k = 0; k < POINTS / 2; k++) begin
      quad = (k / QUARTER) % 4;
      r    = k % QUARTER;
      x    = (PI_Q40 * 64'(2 * r)) >> (9 + LOG2_POINTS);
      t    = 64'd1 << 31;
      cc   = longint'(64'd1 << 31);
      ss   = 0;
      for (int n = 1; n <= 30; n++) begin
        t = ((t * x) >> 31) / 64'(n);
        case (n % 4)
          1:       ss = ss + longint'(t);
          2:       cc = cc - longint'(t);
          3:       ss = ss - longint'(t);
          default: cc = cc + longint'(t);
        endcase
      end
      case (quad)
        0:       begin c = cc;  s = ss;  end
        1:       begin c = -ss; s = cc;  end
        2:       begin c = -cc; s = -ss; end
        default: begin c = ss;  s = -cc; end
      endcase
      tbl[k] = {quant_q7(c), quant_q7(-s)};
    end
    return tbl;
  endfunction

  localparam logic [POINTS/2-1:0][15:0] TWIDDLES = build_table();

  // Registered read
  always_ff @(posedge clk) begin
    twiddle <= cplx_t'(TWIDDLES[addr]);
  end

endmodule

`default_nettype wire

### hw/rtl/q7fft_butterfly.sv
// ----------------------------------------------------------------------------
// q7fft_butterfly
// Shared scaled radix-2 butterfly: products registered, then round, saturate
// (or pass x_in on bypass), add/subtract and halve, registered again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module q7fft_butterfly
  import q7fft_pkg::*;
(
  input  wire logic  clk,
  input  wire cplx_t a_in,
  input  wire cplx_t x_in,
  input  wire cplx_t w_in,
  input  wire logic  bypass,
  output cplx_t      e_out,
  output cplx_t      o_out
);

  logic signed [15:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  cplx_t              a_r, x_r;
  logic               byp_r;

  logic signed [17:0] sum_re, sum_im;
  logic signed [10:0] sh_re, sh_im;
  logic signed [7:0]  t_re, t_im;
  cplx_t              e_nxt, o_nxt;

  function automatic logic signed [7:0] sat8(input logic signed [10:0] v);
    if (v > 11'sd127) begin
      sat8 = 8'sd127;
    end else if (v < -11'sd128) begin
      sat8 = -8'sd128;
    end else begin
      sat8 = v[7:0];
    end
  endfunction

  // Halve (v + 1) with floor, wrap to 8 bits
  function automatic logic signed [7:0] half8(input logic signed [9:0] v);
    logic signed [9:0] h;
    h = (v + 10'sd1) >>> 1;
    half8 = h[7:0];
  endfunction

  // Stage 1: the four products
  always_ff @(posedge clk) begin
    p_rr_r <= w_in.re * x_in.re;
    p_ii_r <= w_in.im * x_in.im;
    p_ir_r <= w_in.im * x_in.re;
    p_ri_r <= w_in.re * x_in.im;
    a_r    <= a_in;
    x_r    <= x_in;
    byp_r  <= bypass;
  end

  // Stage 2: round, saturate, butterfly
  always_comb begin
    sum_re = 18'(p_rr_r) - 18'(p_ii_r) + 18'sd64;
    sum_im = 18'(p_ir_r) + 18'(p_ri_r) + 18'sd64;
    sh_re  = 11'(sum_re >>> 7);
    sh_im  = 11'(sum_im >>> 7);
    t_re   = byp_r ? x_r.re : sat8(sh_re);
    t_im   = byp_r ? x_r.im : sat8(sh_im);
    e_nxt.re = half8(10'(a_r.re) + 10'(t_re));
    e_nxt.im = half8(10'(a_r.im) + 10'(t_im));
    o_nxt.re = half8(10'(a_r.re) - 10'(t_re));
    o_nxt.im = half8(10'(a_r.im) - 10'(t_im));
  end

  always_ff @(posedge clk) begin
    e_out <= e_nxt;
    o_out <= o_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/q7_radix2_fft_engine_core.sv
// ----------------------------------------------------------------------------
// q7_radix2_fft_engine_core
// In-place scaled radix-2 DIT FFT over complex Q7 samples.
// ----------------------------------------------------------------------------
// Write and read items are taken one per cycle while busy is low; a read's
// bin appears on the out_ ports with out_strobe in the cycle after it is
// accepted, a write or unused code gives a zero result there too. A run item
// keeps busy high for the bit-reversal pass (read, check and, where a swap is
// done, two writes per index) and then the butterflies (read, multiply, add,
// write even, write odd), then strobes its acknowledge; the single write port
// of the sample store and the one shared butterfly unit set this pace. Results
// cannot be held off. Samples read or transformed before being written read
// back unspecified values.
`timescale 1ns / 1ps
`default_nettype none

module q7_radix2_fft_engine_core
  import q7fft_pkg::*;
#(
  parameter int POINTS      = 1024,
  parameter int LOG2_POINTS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_command,
  input  wire logic [9:0]        in_index,
  input  wire logic signed [7:0] in_sample_real,
  input  wire logic signed [7:0] in_sample_imag,
  output logic                   out_strobe,
  output logic signed [7:0]      out_bin_real,
  output logic signed [7:0]      out_bin_imag,
  output logic                   out_read_valid
);

`include "assert_macros.svh"

  localparam int AW = LOG2_POINTS;
  localparam int SW = $clog2(LOG2_POINTS + 1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       rev_i_r, rev_i_nxt;
  logic [AW-2:0]       bf_b_r, bf_b_nxt;
  logic [SW-1:0]       stage_r, stage_nxt;
  logic                strobe_r, strobe_nxt;
  logic                rvalid_r, rvalid_nxt;

  cplx_t               mem [POINTS];
  cplx_t               rd_a_r, rd_b_r;
  logic [AW-1:0]       rd_a_addr, rd_b_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  cplx_t               wr_data;

  logic                accept;
  logic [AW-1:0]       rev_j;
  logic                rev_last, bf_b_last, bf_last;
  logic [AW-1:0]       bx, off, e_addr, o_addr, k_full;
  logic                off_zero;
  cplx_t               twiddle, bf_e, bf_o;

  assign accept = start && !busy;

  // Bit-reversed partner of the sweep index
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_j[b] = rev_i_r[AW-1-b];
    end
  end

  assign rev_last  = (rev_i_r == {AW{1'b1}});
  assign bf_b_last = (bf_b_r == {(AW-1){1'b1}});
  assign bf_last   = bf_b_last && (stage_r == SW'(LOG2_POINTS - 1));

  // Butterfly addresses and twiddle index for stage s, butterfly b
  always_comb begin
    bx       = {1'b0, bf_b_r};
    off      = bx & ((AW'(1) << stage_r) - AW'(1));
    e_addr   = ((bx >> stage_r) << (stage_r + SW'(1))) | off;
    o_addr   = e_addr | (AW'(1) << stage_r);
    k_full   = off << (SW'(LOG2_POINTS - 1) - stage_r);
    off_zero = (off == '0);
  end

  q7fft_twiddle_rom #(
    .POINTS      (POINTS),
    .LOG2_POINTS (LOG2_POINTS)
  ) u_rom (
    .clk     (clk),
    .addr    (k_full[AW-2:0]),
    .twiddle (twiddle)
  );

  q7fft_butterfly u_bf (
    .clk    (clk),
    .a_in   (rd_a_r),
    .x_in   (rd_b_r),
    .w_in   (twiddle),
    .bypass (off_zero),
    .e_out  (bf_e),
    .o_out  (bf_o)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept && in_command == CMD_RUN) state_nxt = ST_REV_RD;
      ST_REV_RD:  state_nxt = ST_REV_CHK;
      ST_REV_CHK: begin
        if (rev_j > rev_i_r) begin
          state_nxt = ST_REV_WA;
        end else begin
          state_nxt = rev_last ? ST_BF_RD : ST_REV_RD;
        end
      end
      ST_REV_WA:  state_nxt = ST_REV_WB;
      ST_REV_WB:  state_nxt = rev_last ? ST_BF_RD : ST_REV_RD;
      ST_BF_RD:   state_nxt = ST_BF_MUL;
      ST_BF_MUL:  state_nxt = ST_BF_ADD;
      ST_BF_ADD:  state_nxt = ST_BF_WE;
      ST_BF_WE:   state_nxt = ST_BF_WO;
      ST_BF_WO:   state_nxt = bf_last ? ST_IDLE : ST_BF_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and counters
  always_comb begin
    busy       = (state_r != ST_IDLE);
    rev_i_nxt  = rev_i_r;
    bf_b_nxt   = bf_b_r;
    stage_nxt  = stage_r;
    strobe_nxt = 1'b0;
    rvalid_nxt = 1'b0;
    rd_a_addr  = e_addr;
    rd_b_addr  = o_addr;
    wr_en      = 1'b0;
    wr_addr    = e_addr;
    wr_data    = bf_e;
    case (state_r)
      ST_IDLE: begin
        rd_a_addr = AW'(in_index);
        wr_addr   = AW'(in_index);
        wr_data   = {in_sample_real, in_sample_imag};
        wr_en     = accept && (in_command == CMD_WRITE);
        strobe_nxt = accept && (in_command != CMD_RUN);
        rvalid_nxt = accept && (in_command == CMD_READ);
        rev_i_nxt  = '0;
        bf_b_nxt   = '0;
        stage_nxt  = '0;
      end
      ST_REV_RD: begin
        rd_a_addr = rev_i_r;
        rd_b_addr = rev_j;
      end
      ST_REV_CHK: begin
        // keep both read ports on the pair until the swap is written
        rd_a_addr = rev_i_r;
        rd_b_addr = rev_j;
        if (!(rev_j > rev_i_r)) rev_i_nxt = rev_i_r + AW'(1);
      end
      ST_REV_WA: begin
        rd_a_addr = rev_i_r;
        rd_b_addr = rev_j;
        wr_en   = 1'b1;
        wr_addr = rev_i_r;
        wr_data = rd_b_r;
      end
      ST_REV_WB: begin
        rd_a_addr = rev_i_r;
        rd_b_addr = rev_j;
        wr_en     = 1'b1;
        wr_addr   = rev_j;
        wr_data   = rd_a_r;
        rev_i_nxt = rev_i_r + AW'(1);
      end
      ST_BF_WE: begin
        wr_en   = 1'b1;
        wr_addr = e_addr;
        wr_data = bf_e;
      end
      ST_BF_WO: begin
        wr_en      = 1'b1;
        wr_addr    = o_addr;
        wr_data    = bf_o;
        bf_b_nxt   = bf_b_r + (AW-1)'(1);
        strobe_nxt = bf_last;
        if (bf_b_last) stage_nxt = stage_r + SW'(1);
      end
      default: begin
      end
    endcase
  end

  // Sample store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rev_i_r  <= '0;
      bf_b_r   <= '0;
      stage_r  <= '0;
      strobe_r <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rev_i_r  <= rev_i_nxt;
      bf_b_r   <= bf_b_nxt;
      stage_r  <= stage_nxt;
      strobe_r <= strobe_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  // Result ports: bin only for a read
  assign out_strobe     = strobe_r;
  assign out_read_valid = rvalid_r;
  assign out_bin_real   = rvalid_r ? rd_a_r.re : 8'sd0;
  assign out_bin_imag   = rvalid_r ? rd_a_r.im : 8'sd0;

  // Checks
  `Q7_ASSERT(a_quick_ack, (accept && in_command != CMD_RUN) |=> out_strobe, "no result for item")
  `Q7_ASSERT(a_run_ack, $fell(busy) |-> out_strobe, "run finished without acknowledge")
  `Q7_ASSERT(a_run_busy, (accept && in_command == CMD_RUN) |=> (busy && !out_strobe), "run not busy")
  `Q7_ASSERT(a_rvalid, out_read_valid |-> out_strobe, "read data without strobe")

endmodule

`default_nettype wire
